// ----- rtl/bnc_pkg.sv -----
// bnc_pkg: shared types and constants for the bracket nesting checker
// character codes, stack entry kinds and the item and result structs
// no dependencies
package bnc_pkg;

	localparam int DEFAULT_STACK_DEPTH   = 256;
	localparam int DEFAULT_POSITION_BITS = 16;
	localparam int FAIL_POS_BITS         = 16;
	localparam int SYMBOL_BITS           = 8;

	localparam logic [SYMBOL_BITS-1:0] CH_LPAREN  = 8'h28;
	localparam logic [SYMBOL_BITS-1:0] CH_RPAREN  = 8'h29;
	localparam logic [SYMBOL_BITS-1:0] CH_STAR    = 8'h2A;
	localparam logic [SYMBOL_BITS-1:0] CH_LSQUARE = 8'h5B;
	localparam logic [SYMBOL_BITS-1:0] CH_RSQUARE = 8'h5D;
	localparam logic [SYMBOL_BITS-1:0] CH_LCURLY  = 8'h7B;
	localparam logic [SYMBOL_BITS-1:0] CH_RCURLY  = 8'h7D;
	localparam logic [SYMBOL_BITS-1:0] CH_LANGLE  = 8'h3C;
	localparam logic [SYMBOL_BITS-1:0] CH_RANGLE  = 8'h3E;

	typedef enum logic [2:0] {
		KIND_PAREN  = 3'd1,
		KIND_PAIR   = 3'd2,
		KIND_SQUARE = 3'd3,
		KIND_CURLY  = 3'd4,
		KIND_ANGLE  = 3'd5
	} kind_t;

	// paren_below marks a '(' stacked directly under this kind
	typedef struct packed {
		logic  paren_below;
		kind_t kind;
	} entry_t;

	typedef struct packed {
		logic [SYMBOL_BITS-1:0] symbol;
		logic                   last_of_line;
		logic                   no_symbol;
	} item_t;

	typedef struct packed {
		logic                     balanced;
		logic [FAIL_POS_BITS-1:0] fail_position;
	} result_t;

endpackage

// ----- rtl/bnc_if.sv -----
// bnc_if: valid/ready channels of the bracket nesting checker
// character channel in, verdict channel out; uses bnc_pkg
interface bnc_char_if import bnc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [SYMBOL_BITS-1:0] symbol;
	logic                   last_of_line;
	logic                   no_symbol;

	modport source (output valid, symbol, last_of_line, no_symbol, input ready);
	modport sink (input valid, symbol, last_of_line, no_symbol, output ready);
endinterface

interface bnc_verdict_if import bnc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     balanced;
	logic [FAIL_POS_BITS-1:0] fail_position;

	modport source (output valid, balanced, fail_position, input ready);
	modport sink (input valid, balanced, fail_position, output ready);
endinterface

// ----- rtl/bracket_nesting_checker_top.sv -----
// a verdict is registered from the line-end character in item_s1 into res_s2, or into
// skid_q while res_s2 still holds an earlier verdict
// throughput: one character per cycle; ready drops only while two verdicts wait
// reset: arst_n clears line state and handshake state at once; the stack memory
// is not cleared, only entries written during the current line are read
// uses bnc_pkg, bnc_if, bnc_core
module bracket_nesting_checker_top import bnc_pkg::*; #(
	parameter int STACK_DEPTH   = DEFAULT_STACK_DEPTH,
	parameter int POSITION_BITS = DEFAULT_POSITION_BITS
) (
	input logic         clk,
	input logic         arst_n,
	bnc_char_if.sink    chars,
	bnc_verdict_if.source verdict
);

	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t skid_q;
	logic    skid_valid_q;

	logic    go, take, pop;
	logic    has_result;
	result_t result;

	assign go    = valid_s1 && !skid_valid_q;
	assign take  = chars.valid && chars.ready;
	assign pop   = valid_s2 && verdict.ready;

	assign chars.ready           = !valid_s1 || go;
	assign verdict.valid         = valid_s2;
	assign verdict.balanced      = res_s2.balanced;
	assign verdict.fail_position = res_s2.fail_position;

	bnc_core #(
		.STACK_DEPTH   (STACK_DEPTH),
		.POSITION_BITS (POSITION_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.item       (item_s1),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (go)
				valid_s1 <= 1'b0;

			if (!valid_s2 || pop) begin
				valid_s2     <= skid_valid_q || has_result;
				skid_valid_q <= skid_valid_q && has_result;
			end else if (has_result) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.symbol       <= chars.symbol;
			item_s1.last_of_line <= chars.last_of_line;
			item_s1.no_symbol    <= chars.no_symbol;
		end

		// the skid entry is older, so it moves up first
		if (!valid_s2 || pop) begin
			if (skid_valid_q) begin
				res_s2 <= skid_q;
				if (has_result)
					skid_q <= result;
			end else begin
				res_s2 <= result;
			end
		end else if (has_result) begin
			skid_q <= result;
		end
	end

endmodule

// ----- rtl/bnc_core.sv -----
// bnc_core: line state and bracket stack, one character per cycle while go is high
// top of stack in a register, lower entries in a memory with a registered read
// uses bnc_pkg
module bnc_core import bnc_pkg::*; #(
	parameter int STACK_DEPTH   = DEFAULT_STACK_DEPTH,
	parameter int POSITION_BITS = DEFAULT_POSITION_BITS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    go,
	input  item_t   item,
	output logic    has_result,
	output result_t result
);

	localparam int LW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int PW = POSITION_BITS + FAIL_POS_BITS;

	entry_t mem [STACK_DEPTH];

	logic [LW-1:0]            level_q, level_n;
	logic [LW-1:0]            phys_q, phys_n;
	entry_t                   top_q, top_n;
	entry_t                   below_q;
	logic                     pparen_q, pparen_n;
	logic                     pstar_q, pstar_n;
	logic                     failed_q, failed_n;
	logic [POSITION_BITS-1:0] count_q, count_n;
	logic [POSITION_BITS-1:0] cnt_inc, count_plus, pos;
	logic [PW-1:0]            pos_wide;

	logic    full, full2;
	logic    do_push, push_two, do_close;
	kind_t   push_kind, close_kind;
	logic    end_fail, still_open;
	logic    wr_en;
	entry_t  wr_data;
	logic [LW-1:0] phys_m1, rd_diff;
	logic [AW-1:0] wr_addr, rd_addr;

	assign full    = level_q >= LW'(STACK_DEPTH);
	assign full2   = level_q >= LW'(STACK_DEPTH - 1);
	assign cnt_inc = (count_q != '1) ? count_q + POSITION_BITS'(1) : count_q;
	assign phys_m1 = phys_q - LW'(1);
	assign wr_addr = phys_m1[AW-1:0];
	assign wr_data = top_q;
	assign rd_diff = phys_n - LW'(2);
	assign rd_addr = rd_diff[AW-1:0];

	always_comb begin
		level_n    = level_q;
		phys_n     = phys_q;
		top_n      = top_q;
		pparen_n   = pparen_q;
		pstar_n    = pstar_q;
		failed_n   = failed_q;
		count_n    = count_q;
		do_push    = 1'b0;
		push_two   = 1'b0;
		push_kind  = KIND_PAREN;
		do_close   = 1'b0;
		close_kind = KIND_PAREN;
		wr_en      = 1'b0;
		end_fail   = 1'b0;
		still_open = 1'b0;
		count_plus = '0;
		pos        = '0;
		pos_wide   = '0;
		has_result = 1'b0;
		result     = '0;

		if (go && !item.no_symbol && !failed_q) begin
			if (pparen_q) begin
				pparen_n = 1'b0;
				if (item.symbol == CH_STAR) begin
					do_push   = 1'b1;
					push_kind = KIND_PAIR;
				end else if (full) begin
					failed_n = 1'b1;
				end else begin
					// the held '(' goes on the stack, then the character acts on it
					count_n   = cnt_inc;
					do_push   = 1'b1;
					push_kind = KIND_PAREN;
					case (item.symbol)
						CH_LPAREN: pparen_n = 1'b1;
						CH_LSQUARE: begin
							push_two  = 1'b1;
							push_kind = KIND_SQUARE;
						end
						CH_LCURLY: begin
							push_two  = 1'b1;
							push_kind = KIND_CURLY;
						end
						CH_LANGLE: begin
							push_two  = 1'b1;
							push_kind = KIND_ANGLE;
						end
						CH_RPAREN: do_push = 1'b0;
						CH_RSQUARE, CH_RCURLY, CH_RANGLE: begin
							do_push  = 1'b0;
							failed_n = 1'b1;
						end
						default: ;
					endcase
				end
			end else begin
				pstar_n = 1'b0;
				if (pstar_q && item.symbol == CH_RPAREN) begin
					do_close   = 1'b1;
					close_kind = KIND_PAIR;
				end else begin
					count_n = cnt_inc;
					case (item.symbol)
						CH_LPAREN: pparen_n = 1'b1;
						CH_STAR:   pstar_n = 1'b1;
						CH_LSQUARE: begin
							do_push   = 1'b1;
							push_kind = KIND_SQUARE;
						end
						CH_LCURLY: begin
							do_push   = 1'b1;
							push_kind = KIND_CURLY;
						end
						CH_LANGLE: begin
							do_push   = 1'b1;
							push_kind = KIND_ANGLE;
						end
						CH_RPAREN: begin
							do_close   = 1'b1;
							close_kind = KIND_PAREN;
						end
						CH_RSQUARE: begin
							do_close   = 1'b1;
							close_kind = KIND_SQUARE;
						end
						CH_RCURLY: begin
							do_close   = 1'b1;
							close_kind = KIND_CURLY;
						end
						CH_RANGLE: begin
							do_close   = 1'b1;
							close_kind = KIND_ANGLE;
						end
						default: ;
					endcase
				end
			end
		end

		// one physical push covers a '(' plus the bracket opened after it
		if (do_push) begin
			if (push_two ? full2 : full) begin
				failed_n = 1'b1;
			end else begin
				wr_en   = phys_q != '0;
				top_n   = '{paren_below: push_two, kind: push_kind};
				phys_n  = phys_q + LW'(1);
				level_n = level_q + (push_two ? LW'(2) : LW'(1));
			end
		end

		if (do_close) begin
			if (level_q == '0 || top_q.kind != close_kind) begin
				failed_n = 1'b1;
			end else if (top_q.paren_below) begin
				top_n   = '{paren_below: 1'b0, kind: KIND_PAREN};
				level_n = level_q - LW'(1);
			end else begin
				top_n   = below_q;
				phys_n  = phys_q - LW'(1);
				level_n = level_q - LW'(1);
			end
		end

		if (go && item.last_of_line) begin
			// a held '(' at line end is an open paren, a held '*' is dropped
			end_fail   = failed_n || (pparen_n && level_n >= LW'(STACK_DEPTH));
			still_open = level_n != '0 || pparen_n;
			count_plus = (count_n != '1) ? count_n + POSITION_BITS'(1) : count_n;
			if (end_fail)
				pos = count_n;
			else if (still_open)
				pos = count_plus;
			pos_wide   = PW'(pos);
			has_result = 1'b1;
			result.balanced      = !end_fail && !still_open;
			result.fail_position = (pos_wide > PW'({FAIL_POS_BITS{1'b1}})) ?
				'1 : pos_wide[FAIL_POS_BITS-1:0];
			level_n  = '0;
			phys_n   = '0;
			pparen_n = 1'b0;
			pstar_n  = 1'b0;
			failed_n = 1'b0;
			count_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			phys_q   <= '0;
			pparen_q <= 1'b0;
			pstar_q  <= 1'b0;
			failed_q <= 1'b0;
			count_q  <= '0;
		end else begin
			level_q  <= level_n;
			phys_q   <= phys_n;
			pparen_q <= pparen_n;
			pstar_q  <= pstar_n;
			failed_q <= failed_n;
			count_q  <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_n;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// entry under the new top, forwarded when it is written in the same cycle
	always_ff @(posedge clk) begin
		if (phys_n >= LW'(2))
			below_q <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
	end

endmodule

// ----- rtl/bnc_checker.sv -----
// bnc_checker: port-level assertions for bracket_nesting_checker_top
// attached by the bind at the end of this file; uses bnc_pkg
module bnc_checker import bnc_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     in_last,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic                     balanced,
	input logic [FAIL_POS_BITS-1:0] fail_position
);

	// a waiting verdict holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(balanced) && $stable(fail_position))
		else $error("verdict changed while stalled");

	// input backpressure only comes from verdicts piling up
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no verdict waiting");

	// a fresh verdict goes back to a line-end transfer, through item_s1 and res_s2
	a_verdict_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
		else $error("verdict without a line-end transfer");

	// yes carries position zero, no always names a nonzero token
	a_pos_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (balanced == (fail_position == '0)))
		else $error("fail position inconsistent with verdict");

endmodule

bind bracket_nesting_checker_top bnc_checker u_bnc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (chars.valid),
	.in_ready      (chars.ready),
	.in_last       (chars.last_of_line),
	.out_valid     (verdict.valid),
	.out_ready     (verdict.ready),
	.balanced      (verdict.balanced),
	.fail_position (verdict.fail_position)
);

// ----- bench/testbench.sv -----
// testbench for bracket_nesting_checker_top: drives characters line by line and checks
// every verdict against its typed row or a cycle-free predictor of the bracket stack
// kept here; depends on bnc_pkg, bnc_if and the rtl under rtl/
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bnc_pkg::*;

	localparam int     STACK_DEPTH  = DEFAULT_STACK_DEPTH;
	localparam longint TOKEN_MAX    = (longint'(1) << DEFAULT_POSITION_BITS) - 1;
	localparam longint FIELD_MAX    = (longint'(1) << FAIL_POS_BITS) - 1;
	localparam int     RANDOM_ITEMS = 1800;
	localparam int     SEGMENT      = 300;
	localparam int     LONG_HOLD    = 80;

	localparam logic [SYMBOL_BITS-1:0] BRACKET_CHARS [9] = '{CH_LPAREN, CH_RPAREN, CH_STAR,
		CH_LSQUARE, CH_RSQUARE, CH_LCURLY, CH_RCURLY, CH_LANGLE, CH_RANGLE};
	localparam logic [SYMBOL_BITS-1:0] LETTER = 8'h61;

	typedef struct packed {
		item_t   item;
		logic    typed;
		result_t verdict;
	} row_t;

	// short lines: empty, pairs, "(*)", "(**)", pending flags at line end, stray closers
	localparam row_t DIRECTED_ROWS [25] = '{
		'{'{8'hA5, 1'b1, 1'b1}, 1'b1, '{1'b1, 16'd0}},
		'{'{CH_LPAREN, 1'b0, 1'b0}, 1'b0, '{1'b0, 16'd0}},
		'{'{CH_RPAREN, 1'b1, 1'b0}, 1'b1, '{1'b1, 16'd0}},
		'{'{CH_LPAREN, 1'b0, 1'b0}, 1'b0, '{1'b0, 16'd0}},
		'{'{CH_STAR, 1'b0, 1'b0}, 1'b0, '{1'b0, 16'd0}},
		'{'{CH_RPAREN, 1'b1, 1'b0}, 1'b1, '{1'b0, 16'd2}},
		'{'{CH_LPAREN, 1'b0, 1'b0}, 1'b0, '{1'b0, 16'd0}},
		'{'{CH_STAR, 1'b0, 1'b0}, 1'b0, '{1'b0, 16'd0}},
		'{'{CH_STAR, 1'b0, 1'b0}, 1'b0, '{1'b0, 16'd0}},
		'{'{CH_RPAREN, 1'b1, 1'b0}, 1'b1, '{1'b1, 16'd0}},
		'{'{CH_LSQUARE, 1'b0, 1'b0}, 1'b0, '{1'b0, 16'd0}},
		'{'{CH_LANGLE, 1'b0, 1'b0}, 1'b0, '{1'b0, 16'd0}},
		'{'{8'hFF, 1'b0, 1'b1}, 1'b0, '{1'b0, 16'd0}},
		'{'{CH_LCURLY, 1'b0, 1'b0}, 1'b0, '{1'b0, 16'd0}},
		'{'{CH_RCURLY, 1'b0, 1'b0}, 1'b0, '{1'b0, 16'd0}},
		'{'{CH_RANGLE, 1'b0, 1'b0}, 1'b0, '{1'b0, 16'd0}},
		'{'{CH_RSQUARE, 1'b1, 1'b0}, 1'b1, '{1'b1, 16'd0}},
		'{'{CH_LPAREN, 1'b1, 1'b0}, 1'b1, '{1'b0, 16'd2}},
		'{'{CH_STAR, 1'b1, 1'b0}, 1'b1, '{1'b1, 16'd0}},
		'{'{CH_RCURLY, 1'b1, 1'b0}, 1'b1, '{1'b0, 16'd1}},
		'{'{8'h00, 1'b0, 1'b0}, 1'b0, '{1'b0, 16'd0}},
		'{'{8'hFF, 1'b1, 1'b0}, 1'b1, '{1'b1, 16'd0}},
		'{'{CH_LPAREN, 1'b0, 1'b0}, 1'b0, '{1'b0, 16'd0}},
		'{'{CH_RSQUARE, 1'b0, 1'b0}, 1'b0, '{1'b0, 16'd0}},
		'{'{CH_RANGLE, 1'b1, 1'b0}, 1'b1, '{1'b0, 16'd2}}
	};

	logic clk;
	logic arst_n;

	bnc_char_if    chars_bus();
	bnc_verdict_if verdict_bus();

	bracket_nesting_checker_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_bus),
		.verdict (verdict_bus)
	);

	// predictor state for the line in progress
	kind_t  open_kinds [STACK_DEPTH];
	int     open_level;
	bit     paren_waiting;
	bit     star_waiting;
	bit     line_failed;
	longint line_tokens;

	result_t expected_verdicts [$];
	item_t   line_chars [$];
	int      error_count;
	int      chars_sent;
	bit      idling_on;
	bit      long_hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void push_open(kind_t k);
		if (open_level >= STACK_DEPTH) begin
			line_failed = 1'b1;
		end else begin
			open_kinds[open_level] = k;
			open_level++;
		end
	endfunction

	function automatic void pop_open(kind_t k);
		if (open_level == 0 || open_kinds[open_level-1] != k) begin
			line_failed = 1'b1;
		end else begin
			open_level--;
		end
	endfunction

	// updates the line state; returns 1 with the verdict when the item ends a line
	function automatic bit predict_verdict(item_t it, output result_t verdict_out);
		bit     counted;
		longint where;
		verdict_out = '0;
		if (!it.no_symbol && !line_failed) begin
			counted = 1'b1;
			if (paren_waiting) begin
				paren_waiting = 1'b0;
				if (it.symbol == CH_STAR) begin
					push_open(KIND_PAIR);
					counted = 1'b0;
				end else begin
					push_open(KIND_PAREN);
				end
			end else if (star_waiting) begin
				star_waiting = 1'b0;
				if (it.symbol == CH_RPAREN) begin
					pop_open(KIND_PAIR);
					counted = 1'b0;
				end
			end
			if (counted && !line_failed) begin
				if (line_tokens < TOKEN_MAX)
					line_tokens++;
				case (it.symbol)
					CH_LPAREN:  paren_waiting = 1'b1;
					CH_STAR:    star_waiting = 1'b1;
					CH_LSQUARE: push_open(KIND_SQUARE);
					CH_LCURLY:  push_open(KIND_CURLY);
					CH_LANGLE:  push_open(KIND_ANGLE);
					CH_RPAREN:  pop_open(KIND_PAREN);
					CH_RSQUARE: pop_open(KIND_SQUARE);
					CH_RCURLY:  pop_open(KIND_CURLY);
					CH_RANGLE:  pop_open(KIND_ANGLE);
					default: ;
				endcase
			end
		end
		if (!it.last_of_line)
			return 1'b0;

		// a '(' still waiting at line end opens a plain paren, a waiting '*' is dropped
		if (!line_failed && paren_waiting)
			push_open(KIND_PAREN);
		if (line_failed)
			where = line_tokens;
		else if (open_level != 0)
			where = (line_tokens < TOKEN_MAX) ? line_tokens + 1 : TOKEN_MAX;
		else
			where = 0;
		if (where > FIELD_MAX)
			where = FIELD_MAX;
		verdict_out.balanced = !line_failed && open_level == 0;
		verdict_out.fail_position = where[FAIL_POS_BITS-1:0];

		open_level = 0;
		paren_waiting = 1'b0;
		star_waiting = 1'b0;
		line_failed = 1'b0;
		line_tokens = 0;
		return 1'b1;
	endfunction

	function automatic void add_char(logic [SYMBOL_BITS-1:0] sym, bit last = 1'b0,
			bit none = 1'b0);
		item_t it;
		it.symbol = sym;
		it.last_of_line = last;
		it.no_symbol = none;
		line_chars.push_back(it);
	endfunction

	function automatic void add_run(logic [SYMBOL_BITS-1:0] sym, int count);
		for (int i = 0; i < count; i++)
			add_char(sym);
	endfunction

	function automatic void emit_kind(kind_t k, bit closing);
		case (k)
			KIND_PAREN:  add_char(closing ? CH_RPAREN : CH_LPAREN);
			KIND_PAIR: begin
				add_char(closing ? CH_STAR : CH_LPAREN);
				add_char(closing ? CH_RPAREN : CH_STAR);
			end
			KIND_SQUARE: add_char(closing ? CH_RSQUARE : CH_LSQUARE);
			KIND_CURLY:  add_char(closing ? CH_RCURLY : CH_LCURLY);
			default:     add_char(closing ? CH_RANGLE : CH_LANGLE);
		endcase
	endfunction

	// well-nested lines with random filler, some left open, some with one char broken, some pure noise
	function automatic void compose_line();
		kind_t            open_plan [$];
		int unsigned      style;
		int unsigned      len;
		int unsigned      pick;
		int               start;
		logic [SYMBOL_BITS-1:0] c;
		start = line_chars.size();
		style = $urandom_range(0, 9);
		len = $urandom_range(0, 24);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 5);
			if ($urandom_range(0, 19) == 0)
				add_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			if (style == 0) begin
				if ($urandom_range(0, 3) == 0)
					add_char(8'($urandom_range(0, 255)));
				else
					add_char(BRACKET_CHARS[$urandom_range(0, 8)]);
			end else if (pick < 2) begin
				open_plan.push_back(kind_t'($urandom_range(1, 5)));
				emit_kind(open_plan[$], 1'b0);
			end else if (pick < 4 && open_plan.size() != 0) begin
				emit_kind(open_plan.pop_back(), 1'b1);
			end else begin
				do
					c = 8'($urandom_range(0, 255));
				while (c inside {CH_LPAREN, CH_RPAREN, CH_STAR, CH_LSQUARE, CH_RSQUARE,
					CH_LCURLY, CH_RCURLY, CH_LANGLE, CH_RANGLE});
				add_char(c);
			end
		end
		if (style != 0 && $urandom_range(0, 3) != 0)
			while (open_plan.size() != 0)
				emit_kind(open_plan.pop_back(), 1'b1);
		if (style == 1 && line_chars.size() > start) begin
			pick = $urandom_range(start, line_chars.size() - 1);
			line_chars[pick].symbol = BRACKET_CHARS[$urandom_range(0, 8)];
			line_chars[pick].no_symbol = 1'b0;
		end
		if (line_chars.size() == start || $urandom_range(0, 5) == 0)
			add_char(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		else
			line_chars[line_chars.size()-1].last_of_line = 1'b1;
	endfunction

	task automatic offer_char(item_t it, bit typed, result_t typed_verdict);
		result_t predicted;
		chars_bus.valid <= 1'b1;
		chars_bus.symbol <= it.symbol;
		chars_bus.last_of_line <= it.last_of_line;
		chars_bus.no_symbol <= it.no_symbol;
		do
			@(posedge clk);
		while (!chars_bus.ready);
		if (predict_verdict(it, predicted))
			expected_verdicts.push_back(typed ? typed_verdict : predicted);
		@(negedge clk);
	endtask

	task automatic idle_sender(int cycles);
		chars_bus.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic wait_for_verdicts();
		chars_bus.valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_verdicts.size() != 0);
	endtask

	task automatic send_queued();
		item_t it;
		while (line_chars.size() != 0) begin
			it = line_chars.pop_front();
			if (idling_on && $urandom_range(0, 3) == 0)
				idle_sender($urandom_range(1, 4));
			offer_char(it, 1'b0, '0);
			// a symbol-less item inside a line is ignored by the block
			if (!it.no_symbol || it.last_of_line)
				chars_sent++;
		end
	endtask

	task automatic note_failure(string msg);
		error_count++;
		if (error_count <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	initial begin
		int unsigned stall;
		verdict_bus.ready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall = LONG_HOLD;
			end else if (stall == 0 && idling_on && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 4);
			end
			verdict_bus.ready <= (stall == 0);
			if (stall > 0)
				stall--;
		end
	end

	always @(posedge clk) begin : verdict_monitor
		result_t want;
		if (arst_n && verdict_bus.valid && verdict_bus.ready) begin
			if (expected_verdicts.size() == 0) begin
				note_failure($sformatf("verdict with none expected: balanced %0b position %0d",
					verdict_bus.balanced, verdict_bus.fail_position));
			end else begin
				want = expected_verdicts.pop_front();
				if (verdict_bus.balanced !== want.balanced)
					note_failure($sformatf("balanced expected %0b got %0b",
						want.balanced, verdict_bus.balanced));
				if (verdict_bus.fail_position !== want.fail_position)
					note_failure($sformatf("fail_position expected %0d got %0d",
						want.fail_position, verdict_bus.fail_position));
			end
		end
	end

	initial begin
		int segment;
		bit hold_done;
		bit drain_done;
		chars_bus.valid = 1'b0;
		chars_bus.symbol = '0;
		chars_bus.last_of_line = 1'b0;
		chars_bus.no_symbol = 1'b0;
		open_level = 0;
		paren_waiting = 1'b0;
		star_waiting = 1'b0;
		line_failed = 1'b0;
		line_tokens = 0;
		error_count = 0;
		chars_sent = 0;
		idling_on = 1'b1;
		long_hold_req = 1'b0;
		hold_done = 1'b0;
		drain_done = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED_ROWS[i]) begin
			if ($urandom_range(0, 3) == 0)
				idle_sender($urandom_range(1, 4));
			offer_char(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].verdict);
		end

		// full stack, overflow by push, by a waiting '(' at line end and by '(' then a letter
		add_run(CH_LSQUARE, STACK_DEPTH);
		add_run(CH_RSQUARE, STACK_DEPTH - 1);
		add_char(CH_RSQUARE, 1'b1);
		add_run(CH_LSQUARE, STACK_DEPTH + 1);
		add_char(LETTER, 1'b1);
		add_run(CH_LCURLY, STACK_DEPTH);
		add_char(CH_LPAREN, 1'b1);
		add_run(CH_LANGLE, STACK_DEPTH);
		add_char(CH_LPAREN);
		add_char(LETTER, 1'b1);
		add_run(CH_LSQUARE, STACK_DEPTH - 1);
		add_char(CH_LPAREN);
		add_char(CH_STAR);
		add_char(CH_STAR);
		add_char(CH_RPAREN);
		add_run(CH_RSQUARE, STACK_DEPTH - 2);
		add_char(CH_RSQUARE, 1'b1);
		send_queued();
		wait_for_verdicts();

		chars_sent = 0;
		while (chars_sent < RANDOM_ITEMS) begin
			segment = chars_sent / SEGMENT;
			idling_on = chars_sent < RANDOM_ITEMS - SEGMENT && segment % 3 != 2;
			if (segment == 2 && !hold_done) begin
				long_hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (segment == 4 && !drain_done) begin
				wait_for_verdicts();
				drain_done = 1'b1;
			end
			compose_line();
			send_queued();
		end

		wait_for_verdicts();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
